### src/mmc3s_pkg.sv
// Package with shared types, codes and scramble tables for the MMC3 scrambler front end.
`default_nettype none
package mmc3s_pkg;

  typedef enum logic [1:0] {
    KIND_CPU_WRITE = 2'd0,
    KIND_CPU_READ  = 2'd1,
    KIND_PRG_QUERY = 2'd2,
    KIND_CHR_QUERY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_SUBMAPPER   = 2'd0,
    CFG_ALT_VARIANT = 2'd1,
    CFG_DIP_SWITCH  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam int unsigned CfgDataW = 3;
  localparam int unsigned NumOuter = 4;
  localparam logic [2:0]  DipOffset = 3'd2;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic       core_write;
    logic [2:0] core_reg;
    logic [7:0] core_data;
    logic [7:0] read_data;
    logic [8:0] bank_out;
    logic       resync;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [1:0] idx;
    logic [7:0] data;
  } outer_wr_t;

  typedef struct packed {
    logic [1:0] submapper;
    logic       alt_variant;
    logic [2:0] dip_switch;
  } cfg_t;

  function automatic logic [2:0] addr_map(input logic [1:0] sub, input logic [2:0] sel);
    logic [2:0] r;
    r = sel;
    unique case (sub)
      2'd0: begin
        unique case (sel)
          3'd0: r = 3'd3; 3'd1: r = 3'd2; 3'd2: r = 3'd0; 3'd3: r = 3'd4;
          3'd4: r = 3'd1; 3'd5: r = 3'd5; 3'd6: r = 3'd6; default: r = 3'd7;
        endcase
      end
      2'd1: begin
        unique case (sel)
          3'd0: r = 3'd3; 3'd1: r = 3'd1; 3'd2: r = 3'd0; 3'd3: r = 3'd5;
          3'd4: r = 3'd2; 3'd5: r = 3'd4; 3'd6: r = 3'd6; default: r = 3'd7;
        endcase
      end
      2'd2: begin
        unique case (sel)
          3'd0: r = 3'd5; 3'd1: r = 3'd0; 3'd2: r = 3'd1; 3'd3: r = 3'd2;
          3'd4: r = 3'd3; 3'd5: r = 3'd7; 3'd6: r = 3'd6; default: r = 3'd4;
        endcase
      end
      default: r = sel;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] cmd_map(input logic [1:0] sub, input logic [2:0] cmd);
    logic [2:0] r;
    r = cmd;
    unique case (sub)
      2'd0: begin
        unique case (cmd)
          3'd0: r = 3'd0; 3'd1: r = 3'd3; 3'd2: r = 3'd1; 3'd3: r = 3'd5;
          3'd4: r = 3'd6; 3'd5: r = 3'd7; 3'd6: r = 3'd2; default: r = 3'd4;
        endcase
      end
      2'd1: begin
        unique case (cmd)
          3'd0: r = 3'd0; 3'd1: r = 3'd2; 3'd2: r = 3'd5; 3'd3: r = 3'd3;
          3'd4: r = 3'd6; 3'd5: r = 3'd1; 3'd6: r = 3'd7; default: r = 3'd4;
        endcase
      end
      2'd2: begin
        unique case (cmd)
          3'd0: r = 3'd0; 3'd1: r = 3'd6; 3'd2: r = 3'd3; 3'd3: r = 3'd7;
          3'd4: r = 3'd5; 3'd5: r = 3'd2; 3'd6: r = 3'd4; default: r = 3'd1;
        endcase
      end
      default: r = cmd;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/scrambled_mmc3_front_and_outer_banking.sv
// Top level of the scrambled MMC3 front end with outer banking registers.
//
//   Channel  Handshake            Payload
//   in_      in_valid/in_ready    in_kind, in_addr, in_data
//   out_     out_valid/out_ready  out_core_write .. out_resync
//   cfg_     cfg_we               cfg_index, cfg_data
//
// Each beat passes an input register and a result register; with out_ready high, one
// beat per cycle is sustained. Outer registers update when a beat moves from the
// input register into the result register, so later beats see the new values.
// A stalled output holds both stages; in_ready follows the pipeline's free slot.
// Synchronous reset clears valid flags, configuration and outer registers.
`default_nettype none
module scrambled_mmc3_front_and_outer_banking (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_addr,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_core_write,
  output logic [2:0]       out_core_reg,
  output logic [7:0]       out_core_data,
  output logic [7:0]       out_read_data,
  output logic [8:0]       out_bank_out,
  output logic             out_resync,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [mmc3s_pkg::CfgDataW-1:0] cfg_data
);

  mmc3s_pkg::cfg_t      cfg_r;
  mmc3s_pkg::item_t     item_r;
  logic                 item_vld_r;
  mmc3s_pkg::result_t   res_r;
  mmc3s_pkg::result_t   res_nxt;
  logic                 res_vld_r;
  mmc3s_pkg::outer_wr_t owr;
  logic                 adv;
  logic [7:0]           r0;
  logic [7:0]           r1;

  assign adv      = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (mmc3s_pkg::cfg_idx_t'(cfg_index))
        mmc3s_pkg::CFG_SUBMAPPER:   cfg_r.submapper   <= cfg_data[1:0];
        mmc3s_pkg::CFG_ALT_VARIANT: cfg_r.alt_variant <= cfg_data[0];
        mmc3s_pkg::CFG_DIP_SWITCH:  cfg_r.dip_switch  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (adv) begin
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind <= mmc3s_pkg::kind_t'(in_kind);
      item_r.addr <= in_addr;
      item_r.data <= in_data;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  mmc3s_xlate u_xlate (
    .cfg  (cfg_r),
    .item (item_r),
    .go   (adv),
    .r0   (r0),
    .r1   (r1),
    .res  (res_nxt),
    .owr  (owr)
  );

  mmc3s_outer u_outer (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (owr),
    .r0    (r0),
    .r1    (r1)
  );

  assign out_valid      = res_vld_r;
  assign out_core_write = res_r.core_write;
  assign out_core_reg   = res_r.core_reg;
  assign out_core_data  = res_r.core_data;
  assign out_read_data  = res_r.read_data;
  assign out_bank_out   = res_r.bank_out;
  assign out_resync     = res_r.resync;

endmodule
`default_nettype wire

### src/mmc3s_outer.sv
// Outer register file, four bytes written from the 0x6000 window.
`default_nettype none
module mmc3s_outer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mmc3s_pkg::outer_wr_t wr,
  output logic [7:0]               r0,
  output logic [7:0]               r1
);

  logic [7:0] regs_r [mmc3s_pkg::NumOuter];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mmc3s_pkg::NumOuter; i++) begin
        regs_r[i] <= 8'h00;
      end
    end else if (wr.en) begin
      regs_r[wr.idx] <= wr.data;
    end
  end

  // Only the first two registers steer bank mapping.
  assign r0 = regs_r[0];
  assign r1 = regs_r[1];

endmodule
`default_nettype wire

### src/mmc3s_xlate.sv
// Combinational translation of one beat into a result and an outer register write.
`default_nettype none
module mmc3s_xlate (
  input  wire mmc3s_pkg::cfg_t     cfg,
  input  wire mmc3s_pkg::item_t    item,
  input  wire logic                go,
  input  wire logic [7:0]          r0,
  input  wire logic [7:0]          r1,
  output mmc3s_pkg::result_t       res,
  output mmc3s_pkg::outer_wr_t     owr
);

  logic       in_window;
  logic [2:0] sel;
  logic [2:0] reg_idx;
  logic [7:0] prg_mask;
  logic [7:0] prg_base;
  logic [7:0] prg_bank;
  logic [8:0] chr_bank;

  assign in_window = (item.addr[15:13] == 3'b011);
  assign sel       = {item.addr[14:13], item.addr[0]};
  assign reg_idx   = mmc3s_pkg::addr_map(cfg.submapper, sel);

  always_comb begin
    prg_mask = 8'h3F;
    prg_base = 8'h00;
    if (cfg.alt_variant) begin
      prg_mask = r1[5] ? 8'h1F : 8'h0F;
      prg_base = {2'b00, r1[4], r1[1], 4'h0};
    end
    if (r0[7]) begin
      if (r0[5]) begin
        prg_bank = {3'b000, r0[3:1], item.addr[14:13]};
      end else begin
        prg_bank = {3'b000, r0[3:0], item.addr[13]};
      end
    end else begin
      prg_bank = (prg_base & ~prg_mask) | (item.data & prg_mask);
    end
  end

  always_comb begin
    if (cfg.alt_variant) begin
      chr_bank = {r1[4], (r1[6] ? item.data[7] : r1[1]), item.data[6:0]};
    end else begin
      chr_bank = {1'b0, item.data};
    end
  end

  always_comb begin
    res      = '0;
    owr      = '0;
    owr.idx  = item.addr[1:0];
    owr.data = item.data;
    unique case (item.kind)
      mmc3s_pkg::KIND_CPU_WRITE: begin
        if (item.addr[15]) begin
          res.core_write = 1'b1;
          res.core_reg   = reg_idx;
          if (reg_idx == 3'd0) begin
            res.core_data = {item.data[7:6], 3'b000,
                             mmc3s_pkg::cmd_map(cfg.submapper, item.data[2:0])};
          end else begin
            res.core_data = item.data;
          end
        end else if (in_window && !r1[0]) begin
          res.resync = 1'b1;
          owr.en     = go;
        end
      end
      mmc3s_pkg::KIND_CPU_READ: begin
        if (in_window && ({1'b0, item.addr[1:0]} == mmc3s_pkg::DipOffset)) begin
          res.read_data = {item.data[7:3], cfg.dip_switch};
        end else begin
          res.read_data = item.data;
        end
      end
      mmc3s_pkg::KIND_PRG_QUERY: begin
        res.bank_out = {1'b0, prg_bank};
      end
      default: begin
        res.bank_out = chr_bank;
      end
    endcase
  end

endmodule
`default_nettype wire
